### design/assert_macros.svh
// Assertion macros shared by the design files of the fitness unit.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked while out of reset.
`define GCF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("gcf assertion failed");
// Checked at every edge, reset included.
`define GCF_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("gcf assertion failed");
`else
`define GCF_ASSERT(lbl, prop)
`define GCF_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### design/gcf_pkg.sv
// Types and constants of the graph coloring fitness unit.
// No dependencies; used by gcf_ram users and the top level.
`default_nettype none

package gcf_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int POS_W        = $clog2(MAX_VERTICES);

    localparam int ROW_W     = 16;
    localparam int ROW_IDX_W = $clog2(ROW_W);
    localparam int COLOR_W   = 4;
    localparam int SEEN_W    = 1 << COLOR_W;
    localparam int FIT_W     = 24;
    localparam int CONF_W    = 7;
    localparam int NCOL_W    = 5;
    localparam int VCNT_W    = 5;
    localparam int CPEN_W    = 16;
    localparam int PEN_W     = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VERTEX_COUNT     = 2'd0,
        CFG_CONFLICT_PENALTY = 2'd1,
        CFG_NEW_COLOR_PEN    = 2'd2,
        CFG_REUSED_COLOR_PEN = 2'd3
    } t_cfg_index;

    localparam logic OP_LOAD_ROW = 1'b0;
    localparam logic OP_COLOR    = 1'b1;

    localparam logic [VCNT_W-1:0] VCOUNT_RESET = 5'd10;
    localparam logic [CPEN_W-1:0] CPEN_RESET   = 16'd1000;
    localparam logic [PEN_W-1:0]  NPEN_RESET   = 8'd2;
    localparam logic [PEN_W-1:0]  RPEN_RESET   = 8'd1;

    typedef struct packed {
        logic                 operation;
        logic [ROW_IDX_W-1:0] row_index;
        logic [ROW_W-1:0]     row_bits;
        logic [COLOR_W-1:0]   color;
    } t_in_item;

    typedef struct packed {
        logic [FIT_W-1:0]  fitness;
        logic [CONF_W-1:0] conflict_pairs;
        logic [NCOL_W-1:0] colors_used;
    } t_out_item;

endpackage

`default_nettype wire

### design/gcf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### design/graph_coloring_fitness_unit.sv
// Top level of the graph coloring fitness unit: sequencer, shared adder, output register.
// Depends on gcf_pkg, gcf_ram and assert_macros.svh.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+---------------------------------
//  in       | into unit | i_in_valid / o_in_stall | i_in_data  (gcf_pkg::t_in_item)
//  out      | from unit | o_out_valid / i_out_stall| o_out_data (gcf_pkg::t_out_item)
//  cfg      | into unit | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// A row load is written into the adjacency RAM and leaves the unit idle. A colour for
// vertex p scans every earlier vertex in turn through the shared saturating adder and
// the single read port of the adjacency and colour RAMs, then adds the colour
// penalty, stalling the input meanwhile. After the last colour of a chromosome the
// result moves into the output register, waiting while a stalled result still holds it.
// Reset (synchronous, active low) restores the default registers and clears the run.
`default_nettype none
`include "assert_macros.svh"

module graph_coloring_fitness_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire gcf_pkg::t_in_item                   i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output gcf_pkg::t_out_item                       o_out_data,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [gcf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [gcf_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_PEN  = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [gcf_pkg::VCNT_W-1:0] r_vcount;
    logic [gcf_pkg::CPEN_W-1:0] r_cpen;
    logic [gcf_pkg::PEN_W-1:0]  r_npen;
    logic [gcf_pkg::PEN_W-1:0]  r_rpen;

    // run state
    logic [gcf_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [gcf_pkg::SEEN_W-1:0] r_seen, n_seen;
    logic [gcf_pkg::FIT_W-1:0]  r_fit, n_fit;
    logic [gcf_pkg::CONF_W-1:0] r_conf, n_conf;
    logic [gcf_pkg::NCOL_W-1:0] r_ncol, n_ncol;

    // scan control
    logic [gcf_pkg::POS_W-1:0]   r_j, n_j;
    logic                        r_chk, n_chk;
    logic [gcf_pkg::COLOR_W-1:0] r_color, n_color;
    logic                        r_final, n_final;

    // output register
    logic                r_out_valid, n_out_valid;
    gcf_pkg::t_out_item  r_out_data, n_out_data;

    logic                        in_take, out_take, issue, edge_hit, color_seen, is_last;
    logic                        adj_we;
    logic [gcf_pkg::POS_W-1:0]   adj_waddr;
    logic [gcf_pkg::ROW_W-1:0]   adj_rdata;
    logic                        col_we;
    logic [gcf_pkg::COLOR_W-1:0] col_rdata;
    logic [gcf_pkg::FIT_W-1:0]   add_op, fit_sat;
    logic [gcf_pkg::FIT_W:0]     add_sum;
    int                          eff_count;

    assign in_take     = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

    // adjacency rows: written by loads, read one earlier vertex per cycle
    assign adj_we    = in_take && (i_in_data.operation == gcf_pkg::OP_LOAD_ROW)
                       && (int'(i_in_data.row_index) < gcf_pkg::MAX_VERTICES);
    assign adj_waddr = gcf_pkg::POS_W'(i_in_data.row_index);

    gcf_ram #(
        .WIDTH (gcf_pkg::ROW_W),
        .DEPTH (gcf_pkg::MAX_VERTICES)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (i_in_data.row_bits),
        .i_raddr (r_j),
        .o_rdata (adj_rdata)
    );

    assign col_we = (r_state == ST_PEN);

    gcf_ram #(
        .WIDTH (gcf_pkg::COLOR_W),
        .DEPTH (gcf_pkg::MAX_VERTICES)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (r_pos),
        .i_wdata (r_color),
        .i_raddr (r_j),
        .o_rdata (col_rdata)
    );

    assign issue      = (r_j < r_pos);
    assign edge_hit   = (int'(r_pos) < gcf_pkg::ROW_W)
                        && adj_rdata[gcf_pkg::ROW_IDX_W'(r_pos)]
                        && (col_rdata == r_color);
    assign color_seen = r_seen[r_color];

    // shared saturating adder: conflict penalty while scanning, colour penalty after
    always_comb begin
        if (r_state == ST_SCAN) begin
            add_op = gcf_pkg::FIT_W'(r_cpen);
        end else if (color_seen) begin
            add_op = gcf_pkg::FIT_W'(r_rpen);
        end else begin
            add_op = gcf_pkg::FIT_W'(r_npen);
        end
        add_sum = {1'b0, r_fit} + {1'b0, add_op};
        fit_sat = add_sum[gcf_pkg::FIT_W] ? {gcf_pkg::FIT_W{1'b1}}
                                          : add_sum[gcf_pkg::FIT_W-1:0];
    end

    always_comb begin
        if (r_vcount == '0) begin
            eff_count = 1;
        end else if (int'(r_vcount) > gcf_pkg::MAX_VERTICES) begin
            eff_count = gcf_pkg::MAX_VERTICES;
        end else begin
            eff_count = int'(r_vcount);
        end
        is_last = (int'(r_pos) + 1 >= eff_count);
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_seen      = r_seen;
        n_fit       = r_fit;
        n_conf      = r_conf;
        n_ncol      = r_ncol;
        n_j         = r_j;
        n_chk       = r_chk;
        n_color     = r_color;
        n_final     = r_final;
        n_out_valid = r_out_valid && !out_take;
        n_out_data  = r_out_data;

        case (r_state)
            ST_IDLE: begin
                if (in_take && (i_in_data.operation == gcf_pkg::OP_COLOR)) begin
                    n_color = i_in_data.color;
                    n_j     = '0;
                    n_chk   = 1'b0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // read data arrives in the cycle after its address
                if (issue) begin
                    n_j = r_j + 1'b1;
                end
                n_chk = issue;
                if (r_chk && edge_hit) begin
                    n_fit = fit_sat;
                    if (r_conf != {gcf_pkg::CONF_W{1'b1}}) begin
                        n_conf = r_conf + 1'b1;
                    end
                end
                if (!issue) begin
                    n_state = ST_PEN;
                end
            end
            ST_PEN: begin
                n_fit = fit_sat;
                if (!color_seen) begin
                    n_seen[r_color] = 1'b1;
                    if (r_ncol != {gcf_pkg::NCOL_W{1'b1}}) begin
                        n_ncol = r_ncol + 1'b1;
                    end
                end
                n_final = is_last;
                if (is_last) begin
                    n_state = ST_EMIT;
                end else begin
                    // stays below the effective count, so it never leaves the range
                    n_pos   = r_pos + 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                // hold until the output register frees up
                if (!r_out_valid || out_take) begin
                    n_out_valid                = 1'b1;
                    n_out_data.fitness         = r_fit;
                    n_out_data.conflict_pairs  = r_conf;
                    n_out_data.colors_used     = r_ncol;
                    n_pos                      = '0;
                    n_seen                     = '0;
                    n_fit                      = '0;
                    n_conf                     = '0;
                    n_ncol                     = '0;
                    n_final                    = 1'b0;
                    n_state                    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_seen      <= '0;
            r_fit       <= '0;
            r_conf      <= '0;
            r_ncol      <= '0;
            r_j         <= '0;
            r_chk       <= 1'b0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_seen      <= n_seen;
            r_fit       <= n_fit;
            r_conf      <= n_conf;
            r_ncol      <= n_ncol;
            r_j         <= n_j;
            r_chk       <= n_chk;
            r_final     <= n_final;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_color    <= n_color;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= gcf_pkg::VCOUNT_RESET;
            r_cpen   <= gcf_pkg::CPEN_RESET;
            r_npen   <= gcf_pkg::NPEN_RESET;
            r_rpen   <= gcf_pkg::RPEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (gcf_pkg::t_cfg_index'(i_cfg_index))
                gcf_pkg::CFG_VERTEX_COUNT:
                    r_vcount <= i_cfg_data[gcf_pkg::VCNT_W-1:0];
                gcf_pkg::CFG_CONFLICT_PENALTY:
                    r_cpen   <= i_cfg_data[gcf_pkg::CPEN_W-1:0];
                gcf_pkg::CFG_NEW_COLOR_PEN:
                    r_npen   <= i_cfg_data[gcf_pkg::PEN_W-1:0];
                gcf_pkg::CFG_REUSED_COLOR_PEN:
                    r_rpen   <= i_cfg_data[gcf_pkg::PEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    `GCF_ASSERT(a_colors_match_bitmap, $countones(r_seen) == int'(r_ncol))
    `GCF_ASSERT(a_scan_index_bounded, (r_state == ST_SCAN) |-> (r_j <= r_pos))
    `GCF_ASSERT(a_check_only_in_scan, r_chk |-> (r_state == ST_SCAN))
    `GCF_ASSERT(a_result_from_emit, $rose(o_out_valid) |-> $past(r_state == ST_EMIT))
    `GCF_ASSERT(a_emit_only_final, (r_state == ST_EMIT) |-> r_final)
    `GCF_ASSERT_ALWAYS(a_reset_to_idle, !i_rst_n |=> (r_state == ST_IDLE))

endmodule

`default_nettype wire
